// ===== rtl/mhpq_pkg.sv =====
// mhpq_pkg: shared types, constants and helpers for the min-heap priority queue
`default_nettype none

package mhpq_pkg;

   localparam int MAX_LEVELS   = 6;
   localparam int KEY_BITS     = 32;
   localparam int PAYLOAD_BITS = 32;
   localparam int LEVEL_BITS   = 3;
   localparam int COUNT_BITS   = MAX_LEVELS;
   localparam int ADDR_BITS    = MAX_LEVELS;
   localparam int HEAP_DEPTH   = (1 << MAX_LEVELS) - 1;

   localparam logic [LEVEL_BITS-1:0] LEVELS_RESET = LEVEL_BITS'(MAX_LEVELS);

   localparam logic CMD_ENQUEUE = 1'b0;
   localparam logic CMD_DEQUEUE = 1'b1;

   localparam logic [1:0] STATUS_DONE      = 2'd0;
   localparam logic [1:0] STATUS_REJ_FULL  = 2'd1;
   localparam logic [1:0] STATUS_REJ_EMPTY = 2'd2;

   typedef struct packed {
      logic                           command;
      logic signed [KEY_BITS-1:0]     key_in;
      logic        [PAYLOAD_BITS-1:0] payload_in;
   } req_type;

   typedef struct packed {
      logic        [1:0]              status;
      logic signed [KEY_BITS-1:0]     key_out;
      logic        [PAYLOAD_BITS-1:0] payload_out;
      logic                           now_empty;
      logic        [COUNT_BITS-1:0]   entry_count;
   } rsp_type;

   typedef struct packed {
      logic signed [KEY_BITS-1:0]     key;
      logic        [PAYLOAD_BITS-1:0] payload;
   } entry_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic up_step;
      logic dn_take;
      logic dn_step;
      logic finish;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic enq_ok;
      logic deq_ok;
      logic up_swap;
      logic dn_swap;
      logic now_zero;
   } dp_sts_type;

   // usable slots for a level setting, clamped to one through MAX_LEVELS
   function automatic logic [COUNT_BITS-1:0] capacity(input logic [LEVEL_BITS-1:0] levels);
      logic [LEVEL_BITS-1:0] lv;
      lv = levels;
      if (lv == '0) begin
         lv = LEVEL_BITS'(1);
      end else if (lv > LEVEL_BITS'(MAX_LEVELS)) begin
         lv = LEVEL_BITS'(MAX_LEVELS);
      end
      return {COUNT_BITS{1'b1}} >> (LEVEL_BITS'(MAX_LEVELS) - lv);
   endfunction

endpackage

`default_nettype wire

// ===== rtl/mhpq_ctrl.sv =====
// mhpq_ctrl: sequencer for enqueue sift-up and dequeue sift-down
`default_nettype none

module mhpq_ctrl
   import mhpq_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output ctrl_cmd_type      cmd,
   input  wire dp_sts_type   sts
);

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_UP      = 3'd1;
   localparam logic [2:0] ST_DN_TAKE = 3'd2;
   localparam logic [2:0] ST_DN      = 3'd3;
   localparam logic [2:0] ST_FINISH  = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      req_ready    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (sts.enq_ok) begin
                  state_in = ST_UP;
               end else if (sts.deq_ok) begin
                  state_in = ST_DN_TAKE;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_UP: begin
            cmd.up_step = 1'b1;
            if (!sts.up_swap) begin
               state_in = ST_FINISH;
            end
         end
         ST_DN_TAKE: begin
            cmd.dn_take = 1'b1;
            state_in    = sts.now_zero ? ST_FINISH : ST_DN;
         end
         ST_DN: begin
            cmd.dn_step = 1'b1;
            if (!sts.dn_swap) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== rtl/mhpq_dp.sv =====
// mhpq_dp: heap memory, count, sift registers and result register
`default_nettype none

module mhpq_dp
   import mhpq_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire req_type               req_data,
   output rsp_type                    rsp_data,
   input  wire logic                  csr_wr_en,
   input  wire logic [LEVEL_BITS-1:0] csr_wr_data,
   input  wire ctrl_cmd_type          cmd,
   output dp_sts_type                 sts
);

   entry_type heap_mem [HEAP_DEPTH];

   entry_type                 rd_a_ff, rd_b_ff;
   entry_type                 val_ff, val_in;
   logic [ADDR_BITS-1:0]      cur_ff, cur_in;
   logic [COUNT_BITS-1:0]     count_ff, count_in;
   logic [LEVEL_BITS-1:0]     levels_ff, levels_in;
   logic [1:0]                status_ff, status_in;
   logic [KEY_BITS-1:0]       kout_ff, kout_in;
   logic [PAYLOAD_BITS-1:0]   pout_ff, pout_in;
   rsp_type                   rsp_ff, rsp_in;

   logic                      enq, full, empty;
   logic [ADDR_BITS-1:0]      par_cur, pick_idx, left_in;
   logic [ADDR_BITS:0]        left_w, right_w, cnt_w;
   logic                      has_l, use_r;
   entry_type                 pick_ent;
   logic                      we;
   entry_type                 wdata;
   logic [ADDR_BITS-1:0]      addr_a, addr_b;

   always_comb begin
      enq   = (req_data.command == CMD_ENQUEUE);
      full  = (count_ff >= capacity(levels_ff));
      empty = (count_ff == '0);

      par_cur  = (cur_ff - 1'b1) >> 1;
      left_w   = {cur_ff, 1'b1};
      right_w  = left_w + 1'b1;
      cnt_w    = {1'b0, count_ff};
      has_l    = (left_w < cnt_w);
      use_r    = (right_w < cnt_w) && ($signed(rd_a_ff.key) > $signed(rd_b_ff.key));
      pick_idx = use_r ? right_w[ADDR_BITS-1:0] : left_w[ADDR_BITS-1:0];
      pick_ent = use_r ? rd_b_ff : rd_a_ff;

      sts.enq_ok   = enq && !full;
      sts.deq_ok   = !enq && !empty;
      sts.up_swap  = (cur_ff != '0) && ($signed(rd_a_ff.key) > $signed(val_ff.key));
      sts.dn_swap  = has_l && ($signed(val_ff.key) > $signed(pick_ent.key));
      sts.now_zero = empty;
   end

   // hole-based sift: the moving entry stays in val_ff until its slot is known
   always_comb begin
      we    = cmd.up_step || cmd.dn_step;
      wdata = val_ff;
      if (cmd.up_step && sts.up_swap) begin
         wdata = rd_a_ff;
      end else if (cmd.dn_step && sts.dn_swap) begin
         wdata = pick_ent;
      end

      cur_in = cur_ff;
      if (cmd.load) begin
         cur_in = count_ff;
      end else if (cmd.dn_take) begin
         cur_in = '0;
      end else if (cmd.up_step && sts.up_swap) begin
         cur_in = par_cur;
      end else if (cmd.dn_step && sts.dn_swap) begin
         cur_in = pick_idx;
      end

      left_in = {cur_in[ADDR_BITS-2:0], 1'b1};
      if (cmd.load) begin
         addr_a = enq ? ((count_ff - 1'b1) >> 1) : '0;
         addr_b = count_ff - 1'b1;
      end else begin
         addr_a = cmd.up_step ? ((cur_in - 1'b1) >> 1) : left_in;
         addr_b = left_in + 1'b1;
      end

      val_in = val_ff;
      if (cmd.load) begin
         val_in.key     = req_data.key_in;
         val_in.payload = req_data.payload_in;
      end else if (cmd.dn_take) begin
         val_in = rd_b_ff;
      end

      count_in  = count_ff;
      status_in = status_ff;
      kout_in   = kout_ff;
      pout_in   = pout_ff;
      if (cmd.load) begin
         kout_in = '0;
         pout_in = '0;
         if (enq) begin
            status_in = full ? STATUS_REJ_FULL : STATUS_DONE;
            if (!full) begin
               count_in = count_ff + 1'b1;
            end
         end else begin
            status_in = empty ? STATUS_REJ_EMPTY : STATUS_DONE;
            if (!empty) begin
               count_in = count_ff - 1'b1;
            end
         end
      end else if (cmd.dn_take) begin
         kout_in = rd_a_ff.key;
         pout_in = rd_a_ff.payload;
      end

      rsp_in = rsp_ff;
      if (cmd.finish) begin
         rsp_in.status      = status_ff;
         rsp_in.key_out     = kout_ff;
         rsp_in.payload_out = pout_ff;
         rsp_in.now_empty   = empty;
         rsp_in.entry_count = count_ff;
      end

      levels_in = csr_wr_en ? csr_wr_data : levels_ff;
   end

   always_ff @(posedge clock) begin
      if (we) begin
         heap_mem[cur_ff] <= wdata;
      end
      rd_a_ff <= heap_mem[addr_a];
      rd_b_ff <= heap_mem[addr_b];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         levels_ff <= LEVELS_RESET;
      end else begin
         count_ff  <= count_in;
         levels_ff <= levels_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff    <= val_in;
      cur_ff    <= cur_in;
      status_ff <= status_in;
      kout_ff   <= kout_in;
      pout_ff   <= pout_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

// ===== rtl/min_heap_priority_queue.sv =====
// min_heap_priority_queue: top level joining the sequencer and the heap datapath
//
// req channel: one transfer carries an enqueue (key and payload) or a dequeue.
// rsp channel: exactly one transfer per request with status, the dequeued
//   entry (zero otherwise), the empty flag and the count after the operation.
// csr port: one write sets the number of tree levels in use; writes land at
//   once and are meant for idle periods only.
// sequence per request: rejected requests go straight to the response step; an
//   enqueue sifts up one level per step, a dequeue takes the root and then sifts
//   down one level per step, and a dequeue of the last entry skips the sift.
// one item is in flight at a time; the heap memory has one write and two
//   read ports with registered read data, and each sift step handles one level.
// the next request is taken the cycle after a response is loaded; that
//   response may still wait in the output register.
// a stalled receiver holds the response register; the finished item then
//   waits until it frees, and no further request is taken meanwhile.
// reset empties the heap at once and sets the level count to its maximum.
`default_nettype none

module min_heap_priority_queue
   import mhpq_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire req_type               req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rsp_type                    rsp_data,
   input  wire logic                  csr_wr_en,
   input  wire logic [LEVEL_BITS-1:0] csr_wr_data
);

   ctrl_cmd_type cmd;
   dp_sts_type   sts;

   mhpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   mhpq_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .sts         (sts)
   );

endmodule

`default_nettype wire

// ===== rtl/mhpq_checker.sv =====
// mhpq_checker: port-level assertions for the priority queue, bound to the top level
`default_nettype none

module mhpq_checker
   import mhpq_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_ready,
   input wire rsp_type               rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.now_empty == (rsp_data.entry_count == '0))
      else $error("empty flag disagrees with count");

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != STATUS_DONE |->
         rsp_data.key_out == '0 && rsp_data.payload_out == '0)
      else $error("rejected transfer carries an entry");

   a_empty_reject: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == STATUS_REJ_EMPTY |-> rsp_data.entry_count == '0)
      else $error("empty rejection with entries held");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind min_heap_priority_queue mhpq_checker u_mhpq_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_data    (rsp_data)
);

`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// tb: self-checking testbench for min_heap_priority_queue with a shadow heap scoreboard
module tb;
   import mhpq_pkg::*;

   class heap_shadow;
      logic signed [KEY_BITS-1:0]     key_store [HEAP_DEPTH];
      logic        [PAYLOAD_BITS-1:0] pay_store [HEAP_DEPTH];
      int unsigned                    held;
      int unsigned                    peak;
      logic        [LEVEL_BITS-1:0]   levels;
      rsp_type                        owed_replies [$];
      int unsigned                    errors;
      int unsigned                    checked;
      int unsigned                    completed;
      int unsigned                    full_rejects;
      int unsigned                    empty_rejects;

      function new();
         held = 0;
         peak = 0;
         levels = LEVELS_RESET;
         errors = 0;
         checked = 0;
         completed = 0;
         full_rejects = 0;
         empty_rejects = 0;
      endfunction

      function void set_levels(logic [LEVEL_BITS-1:0] value);
         levels = value;
      endfunction

      function int unsigned slots_allowed();
         int unsigned lv;
         lv = levels;
         if (lv < 1) lv = 1;
         if (lv > MAX_LEVELS) lv = MAX_LEVELS;
         return (1 << lv) - 1;
      endfunction

      function void swap_entries(int unsigned a, int unsigned b);
         logic signed [KEY_BITS-1:0]     k;
         logic        [PAYLOAD_BITS-1:0] p;
         k = key_store[a];
         p = pay_store[a];
         key_store[a] = key_store[b];
         pay_store[a] = pay_store[b];
         key_store[b] = k;
         pay_store[b] = p;
      endfunction

      // note an accepted request and queue the response it must produce
      function void predict_reply(req_type item);
         rsp_type     want;
         int unsigned cur;
         int unsigned child;
         int unsigned pick;
         bit          settled;
         want = '0;
         want.status = STATUS_DONE;
         if (item.command == CMD_ENQUEUE) begin
            if (held >= slots_allowed()) begin
               want.status = STATUS_REJ_FULL;
            end else begin
               cur = held;
               key_store[cur] = item.key_in;
               pay_store[cur] = item.payload_in;
               held++;
               while (cur > 0 && key_store[(cur - 1) / 2] > key_store[cur]) begin
                  swap_entries(cur, (cur - 1) / 2);
                  cur = (cur - 1) / 2;
               end
            end
         end else if (held == 0) begin
            want.status = STATUS_REJ_EMPTY;
         end else begin
            want.key_out = key_store[0];
            want.payload_out = pay_store[0];
            held--;
            key_store[0] = key_store[held];
            pay_store[0] = pay_store[held];
            cur = 0;
            settled = 0;
            while (!settled) begin
               child = 2 * cur + 1;
               if (child >= held) begin
                  settled = 1;
               end else begin
                  pick = child;
                  if (child + 1 < held && key_store[child] > key_store[child + 1]) begin
                     pick = child + 1;
                  end
                  if (key_store[cur] > key_store[pick]) begin
                     swap_entries(cur, pick);
                     cur = pick;
                  end else begin
                     settled = 1;
                  end
               end
            end
         end
         want.now_empty = (held == 0);
         want.entry_count = COUNT_BITS'(held);
         if (held > peak) peak = held;
         case (want.status)
            STATUS_REJ_FULL: full_rejects++;
            STATUS_REJ_EMPTY: empty_rejects++;
            default: completed++;
         endcase
         owed_replies.push_back(want);
      endfunction

      task report(string what, longint got, longint want);
         errors++;
         if (errors <= 40) begin
            $display("ERROR at %0t: %s got %0d expected %0d", $time, what, got, want);
         end
      endtask

      task check_reply(rsp_type got);
         rsp_type want;
         checked++;
         if (owed_replies.size() == 0) begin
            report("response with nothing outstanding, status", got.status, 0);
         end else begin
            want = owed_replies.pop_front();
            if (got.status !== want.status)
               report("status", got.status, want.status);
            if (got.key_out !== want.key_out)
               report("key_out", longint'(got.key_out), longint'(want.key_out));
            if (got.payload_out !== want.payload_out)
               report("payload_out", got.payload_out, want.payload_out);
            if (got.now_empty !== want.now_empty)
               report("now_empty", got.now_empty, want.now_empty);
            if (got.entry_count !== want.entry_count)
               report("entry_count", got.entry_count, want.entry_count);
         end
      endtask
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_wr_en = 1'b0;
   logic [LEVEL_BITS-1:0] csr_wr_data = LEVELS_RESET;

   heap_shadow  shadow = new();
   int unsigned burst_left = 4;
   bit          hold_off = 1'b0;
   bit [7:0]    levels_seen = '0;

   always #4 clock = ~clock;

   min_heap_priority_queue dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) shadow.predict_reply(req_data);
      if (!reset && rsp_valid && rsp_ready) shadow.check_reply(rsp_data);
   end

   // receiver: stall pattern drawn at random from four modes, plus requested long hold-offs
   initial begin
      int unsigned mode;
      int unsigned tick;
      mode = 0;
      tick = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (hold_off) begin
            rsp_ready = 1'b0;
            repeat (400) @(negedge clock);
            hold_off = 1'b0;
         end
         tick++;
         if (tick % 64 == 0) mode = $urandom_range(0, 3);
         case (mode)
            0: rsp_ready = 1'b1;
            1: rsp_ready = $urandom_range(0, 1);
            2: rsp_ready = (tick % 4 == 0);
            default: rsp_ready = ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   // one request transfer, then burst accounting with a random gap at the end of a burst
   task automatic offer(input logic cmd, input logic signed [KEY_BITS-1:0] key,
                        input logic [PAYLOAD_BITS-1:0] payload);
      req_type item;
      item.command = cmd;
      item.key_in = key;
      item.payload_in = payload;
      @(negedge clock);
      req_valid = 1'b1;
      req_data = item;
      do @(posedge clock); while (!req_ready);
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat ($urandom_range(0, 14)) @(negedge clock);
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
                                                  : $urandom_range(1, 12);
      end
   endtask

   task automatic quiesce();
      @(negedge clock);
      req_valid = 1'b0;
      while (shadow.owed_replies.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_levels(input logic [LEVEL_BITS-1:0] value);
      quiesce();
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
      shadow.set_levels(value);
      levels_seen[value] = 1'b1;
   endtask

   function automatic logic signed [KEY_BITS-1:0] pick_key();
      logic signed [KEY_BITS-1:0] k;
      case ($urandom_range(0, 19))
         0: k = {1'b1, {(KEY_BITS - 1){1'b0}}};
         1: k = {1'b0, {(KEY_BITS - 1){1'b1}}};
         2: k = '0;
         3: k = '1;
         4, 5, 6, 7, 8, 9, 10: k = KEY_BITS'($urandom_range(0, 12)) - KEY_BITS'(6);
         default: k = $urandom();
      endcase
      return k;
   endfunction

   function automatic logic [PAYLOAD_BITS-1:0] pick_payload();
      logic [PAYLOAD_BITS-1:0] p;
      case ($urandom_range(0, 9))
         0: p = '0;
         1: p = '1;
         default: p = $urandom();
      endcase
      return p;
   endfunction

   initial begin
      int unsigned random_sent;
      int unsigned phase;
      int unsigned span;
      int unsigned enq_pct;
      int unsigned n;
      int unsigned level_plan [8];
      level_plan = '{3, 7, 1, 5, 0, 6, 2, 4};
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // three slots: empty and full rejects, key and payload extremes, last entry out
      write_levels(2);
      offer(CMD_DEQUEUE, '0, '0);
      offer(CMD_ENQUEUE, {1'b0, {(KEY_BITS - 1){1'b1}}}, '0);
      offer(CMD_ENQUEUE, {1'b1, {(KEY_BITS - 1){1'b0}}}, '1);
      offer(CMD_ENQUEUE, '0, 1);
      offer(CMD_ENQUEUE, 5, 2);
      offer(CMD_DEQUEUE, '0, '0);
      offer(CMD_ENQUEUE, '1, 3);
      offer(CMD_DEQUEUE, '0, '0);
      offer(CMD_DEQUEUE, '0, '0);
      offer(CMD_DEQUEUE, '0, '0);
      offer(CMD_DEQUEUE, '0, '0);

      // equal child keys on sift-down
      write_levels(3);
      offer(CMD_ENQUEUE, 1, 32'h0000_00a1);
      offer(CMD_ENQUEUE, 3, 32'h0000_00b1);
      offer(CMD_ENQUEUE, 3, 32'h0000_00b2);
      offer(CMD_ENQUEUE, 9, 32'h0000_00c1);
      offer(CMD_DEQUEUE, '0, '0);

      // capacity shrunk below the count, then level zero acting as one
      write_levels(1);
      offer(CMD_ENQUEUE, 4, 32'h0000_00d1);
      write_levels(0);
      offer(CMD_ENQUEUE, 4, 32'h0000_00d2);
      offer(CMD_DEQUEUE, '0, '0);
      offer(CMD_DEQUEUE, '0, '0);
      offer(CMD_DEQUEUE, '0, '0);
      offer(CMD_DEQUEUE, '0, '0);
      offer(CMD_ENQUEUE, -7, 32'h0000_00e1);
      offer(CMD_ENQUEUE, -8, 32'h0000_00e2);

      // random phases: fill-leaning first half, drain-leaning second half
      random_sent = 0;
      phase = 0;
      while (random_sent < 1300) begin
         write_levels(level_plan[phase % 8]);
         if (phase == 1 || phase == 6) hold_off = 1'b1;
         span = $urandom_range(40, 180);
         case ($urandom_range(0, 2))
            0: enq_pct = 85;
            1: enq_pct = 70;
            default: enq_pct = 55;
         endcase
         for (n = 0; n < span; n++) begin
            offer(($urandom_range(0, 99) < ((n < span / 2) ? enq_pct : 100 - enq_pct))
                     ? CMD_ENQUEUE : CMD_DEQUEUE,
                  pick_key(), pick_payload());
         end
         random_sent += span;
         phase++;
      end
      quiesce();

      $display("checked %0d responses: %0d completed, %0d rejected full, %0d rejected empty",
               shadow.checked, shadow.completed, shadow.full_rejects, shadow.empty_rejects);
      $display("level settings written (bit per value): %b, deepest fill %0d entries",
               levels_seen, shadow.peak);
      if (shadow.errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
